/* src/csks_pkg.sv */
package csks_pkg;

  localparam int unsigned RoundsReq = 44;
  localparam int unsigned Rounds = (RoundsReq > 44) ? 44 : ((RoundsReq < 1) ? 1 : RoundsReq);
  localparam int unsigned IdxW = 6;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Rounds);

  typedef logic [3:0][31:0] rows_t;

  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
  } in_word_t;

  typedef struct packed {
    logic [63:0]     subkey_high;
    logic [63:0]     subkey_low;
    logic [IdxW-1:0] round_index;
    logic            last_round;
  } out_word_t;

  // Round constant used to produce subkey idx+1.
  function automatic logic [5:0] round_const(input logic [IdxW-1:0] idx);
    logic [5:0] rc;
    case (idx)
      6'd0:  rc = 6'h01;  6'd1:  rc = 6'h02;  6'd2:  rc = 6'h04;  6'd3:  rc = 6'h08;
      6'd4:  rc = 6'h10;  6'd5:  rc = 6'h21;  6'd6:  rc = 6'h03;  6'd7:  rc = 6'h06;
      6'd8:  rc = 6'h0C;  6'd9:  rc = 6'h18;  6'd10: rc = 6'h31;  6'd11: rc = 6'h22;
      6'd12: rc = 6'h05;  6'd13: rc = 6'h0A;  6'd14: rc = 6'h14;  6'd15: rc = 6'h29;
      6'd16: rc = 6'h13;  6'd17: rc = 6'h27;  6'd18: rc = 6'h0F;  6'd19: rc = 6'h1E;
      6'd20: rc = 6'h3D;  6'd21: rc = 6'h3A;  6'd22: rc = 6'h34;  6'd23: rc = 6'h28;
      6'd24: rc = 6'h11;  6'd25: rc = 6'h23;  6'd26: rc = 6'h07;  6'd27: rc = 6'h0E;
      6'd28: rc = 6'h1C;  6'd29: rc = 6'h39;  6'd30: rc = 6'h32;  6'd31: rc = 6'h24;
      6'd32: rc = 6'h09;  6'd33: rc = 6'h12;  6'd34: rc = 6'h25;  6'd35: rc = 6'h0B;
      6'd36: rc = 6'h16;  6'd37: rc = 6'h2D;  6'd38: rc = 6'h1B;  6'd39: rc = 6'h37;
      6'd40: rc = 6'h2E;  6'd41: rc = 6'h1D;  6'd42: rc = 6'h3B;  6'd43: rc = 6'h36;
      default: rc = 6'h00;
    endcase
    return rc;
  endfunction

endpackage

/* src/csks_round.sv */
module csks_round (
  input  csks_pkg::rows_t     rows_in,
  input  logic [5:0]          rc,
  output csks_pkg::rows_t     rows_out
);

  logic [31:0] x02, u, x12, v;
  logic [31:0] s0, s1, s2, s3;

  // Bitsliced 4-bit S-box applied to every column of the four rows.
  always_comb begin
    x02 = rows_in[0] ^ rows_in[2];
    u   = rows_in[3] ^ (rows_in[0] & rows_in[1]);
    x12 = rows_in[1] ^ rows_in[2];
    v   = x02 ^ (rows_in[1] | rows_in[3]);
    s0  = x12 ^ (x02 & u);
    s1  = u ^ (x12 & v);
    s2  = rows_in[2] ^ u;
    s3  = ~v;
  end

  assign rows_out[0] = {s0[24:0], s0[31:25]} ^ s1 ^ {26'd0, rc};
  assign rows_out[1] = s2;
  assign rows_out[2] = {s2[14:0], s2[31:15]} ^ s3;
  assign rows_out[3] = s0;

endmodule

/* src/column_sbox_key_schedule_128.sv */
// The seed key comes out as the first word in the cycle after the key is accepted.
// Throughput: one subkey word per cycle while out_ready is held, 45 words per key,
// all produced by a single shared round unit stepping the key register.
// The next key is accepted the cycle after the last word is taken.
// Reset (rst_n low, synchronous) returns the sequencer to idle; key rows are not reset.
module column_sbox_key_schedule_128 (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  csks_pkg::in_word_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output csks_pkg::out_word_t   out_data
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t                         state_r, state_nxt;
  csks_pkg::rows_t                rows_r, rows_nxt, rows_step;
  logic [csks_pkg::IdxW-1:0]      idx_r, idx_nxt;
  logic                           is_last;

  csks_round u_round (
    .rows_in  (rows_r),
    .rc       (csks_pkg::round_const(idx_r)),
    .rows_out (rows_step)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_RUN);
  assign is_last   = (idx_r == csks_pkg::LastIdx);

  assign out_data.subkey_high = {rows_r[0], rows_r[1]};
  assign out_data.subkey_low  = {rows_r[2], rows_r[3]};
  assign out_data.round_index = idx_r;
  assign out_data.last_round  = is_last;

  always_comb begin
    state_nxt = state_r;
    rows_nxt  = rows_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          rows_nxt  = {in_data.key_low[31:0], in_data.key_low[63:32],
                       in_data.key_high[31:0], in_data.key_high[63:32]};
          idx_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        // The register only advances when the current word has been taken.
        if (out_ready) begin
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            rows_nxt = rows_step;
            idx_nxt  = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rows_r <= rows_nxt;
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted while a run is active");

  a_seed_first: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (out_valid && out_data.round_index == '0
      && out_data.subkey_high == $past(in_data.key_high)
      && out_data.subkey_low == $past(in_data.key_low)))
    else $error("seed key word not emitted first");

  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.last_round) |=>
      (out_valid && out_data.round_index == $past(out_data.round_index) + 1'b1))
    else $error("round index did not advance by one");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last_round) |=> (in_ready && !out_valid))
    else $error("run did not end after the last subkey");

endmodule
